### hdl/lpmd_pkg.sv
`timescale 1ns / 1ps

package lpmd_pkg;

  // ring buffer geometry (depth is a power of two)
  localparam int BufDepth = 4096;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int FillW    = AddrW + 1;

  // frame and field widths
  localparam int ByteW     = 8;
  localparam int LenW      = 16;
  localparam int FillOutW  = 13;
  localparam int FrameOvh  = 3;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_GIVEN   = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // sequencer: normal running, or re-reading the head bytes after a frame leaves
  typedef enum logic [2:0] {
    S_RUN,
    S_FETCH0,
    S_FETCH1,
    S_FETCH2,
    S_FETCH3
  } state_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [ByteW-1:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [ByteW-1:0]     out_byte;
    logic [ByteW-1:0]     frame_header;
    logic [LenW-1:0]      frame_length;
    logic                 last_byte;
    logic                 frame_ready;
    logic [FillOutW-1:0]  fill_level;
  } out_item_t;

endpackage

### hdl/length_prefixed_message_deframer_top.sv
`timescale 1ns / 1ps

// Receive queue for frames of a 16-bit big-endian length, one header byte
// and the payload. Input channel (in_valid/in_ready/in_item): opcode
// OP_RECV appends rx_byte to a 4096-byte ring buffer (dropped and flagged
// when full), OP_READ hands out the next payload byte of the head frame.
// Every accepted item yields exactly one result item on the output channel
// (out_valid/out_ready/out_item), in order.
// An accepted item's partial result waits in a middle stage while the
// synchronous buffer read completes, then moves to the output register.
// Throughput: one item per cycle while the output drains, except after a
// read that removes a frame: the length and header bytes of the new head
// frame are then re-read from the single buffer read port, so no item is
// taken while the sequencer steps through S_FETCH0 to S_FETCH3.
// A stalled receiver holds the output register; one further item can sit in
// the middle stage, after which in_ready drops until the output drains.
// Reset (rst, synchronous) empties the queue and the pipeline; buffer
// contents are not cleared and need no clearing pass.
module length_prefixed_message_deframer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpmd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lpmd_pkg::out_item_t out_item
);
  import lpmd_pkg::*;

  // ring buffer
  logic [ByteW-1:0] mem [BufDepth];
  logic [ByteW-1:0] rdata;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;

  // queue state
  logic [AddrW-1:0] head;
  logic [FillW-1:0] fill;
  logic [LenW-1:0]  read_offset;
  logic [ByteW-1:0] hb0, hb1, hb2;

  state_t state, state_next;

  // middle stage
  logic      b_valid;
  logic      b_from_mem;
  out_item_t b_res;
  out_item_t b_res_next;
  logic      b_adv;
  out_item_t out_next;

  logic      accept;
  logic      head_rdy;
  logic [LenW-1:0] head_len;
  logic      is_read, is_recv, full;
  logic [LenW-1:0] ro;
  logic [LenW:0]   ro_inc;
  logic      rm_last;
  logic      removal;

  // head frame view
  always_comb begin
    head_len = {hb0, hb1};
    head_rdy = (fill >= FillW'(2)) && (head_len != '0) &&
               (32'(fill) >= 32'(head_len) + 32'(FrameOvh));
    full     = (fill >= FillW'(BufDepth));
  end

  assign accept  = in_valid && in_ready;
  assign is_read = (in_item.opcode == OP_READ);
  assign is_recv = (in_item.opcode == OP_RECV);

  // payload byte position and end-of-frame test
  always_comb begin
    ro      = (read_offset >= head_len) ? '0 : read_offset;
    ro_inc  = (LenW+1)'(ro) + (LenW+1)'(1);
    rm_last = (ro_inc >= {1'b0, head_len});
    removal = accept && is_read && head_rdy && rm_last;
  end

  assign b_adv = b_valid && (state == S_RUN) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_RUN:    if (removal) state_next = S_FETCH0;
      S_FETCH0: state_next = S_FETCH1;
      S_FETCH1: state_next = S_FETCH2;
      S_FETCH2: state_next = S_FETCH3;
      S_FETCH3: state_next = S_RUN;
      default:  state_next = S_RUN;
    endcase
  end

  // sequencer outputs: input handshake and buffer read port
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = AddrW'(head + AddrW'(ro) + AddrW'(FrameOvh));
    case (state)
      S_RUN: begin
        in_ready = !b_valid || b_adv;
        rd_en    = accept && is_read && head_rdy;
      end
      S_FETCH0: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      S_FETCH1: begin
        rd_en   = 1'b1;
        rd_addr = AddrW'(head + AddrW'(1));
      end
      S_FETCH2: begin
        rd_en   = 1'b1;
        rd_addr = AddrW'(head + AddrW'(2));
      end
      S_FETCH3: ;
      default: ;
    endcase
  end

  assign wr_en   = accept && is_recv && !full;
  assign wr_addr = AddrW'(head + fill[AddrW-1:0]);

  // buffer write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      fill        <= '0;
      read_offset <= '0;
    end else if (wr_en) begin
      fill <= FillW'(fill + FillW'(1));
    end else if (accept && is_read && head_rdy) begin
      if (rm_last) begin
        head        <= AddrW'(head + AddrW'(head_len) + AddrW'(FrameOvh));
        fill        <= FillW'(32'(fill) - 32'(head_len) - 32'(FrameOvh));
        read_offset <= '0;
      end else begin
        read_offset <= ro_inc[LenW-1:0];
      end
    end
  end

  // head byte copies: from the incoming byte, or re-read after a removal
  always_ff @(posedge clk) begin
    if (wr_en && fill == FillW'(0)) hb0 <= in_item.rx_byte;
    if (wr_en && fill == FillW'(1)) hb1 <= in_item.rx_byte;
    if (wr_en && fill == FillW'(2)) hb2 <= in_item.rx_byte;
    if (state == S_FETCH1) hb0 <= rdata;
    if (state == S_FETCH2) hb1 <= rdata;
    if (state == S_FETCH3) hb2 <= rdata;
  end

  // partial result of the item being accepted
  always_comb begin
    b_res_next = '0;
    if (is_recv) begin
      b_res_next.status = full ? ST_DROPPED : ST_STORED;
    end else if (head_rdy) begin
      b_res_next.status       = ST_GIVEN;
      b_res_next.frame_header = hb2;
      b_res_next.frame_length = head_len;
      b_res_next.last_byte    = rm_last;
    end else begin
      b_res_next.status = ST_EMPTY;
    end
  end

  // middle stage: partial result, payload byte caught from the read port
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      b_from_mem <= 1'b0;
    end else if (accept) begin
      b_valid    <= 1'b1;
      b_from_mem <= is_read && head_rdy;
      b_res      <= b_res_next;
    end else begin
      if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_from_mem) begin
        b_res.out_byte <= rdata;
        b_from_mem     <= 1'b0;
      end
    end
  end

  // output item: queue state here already reflects the item in flight
  always_comb begin
    out_next             = b_res;
    out_next.out_byte    = b_from_mem ? rdata : b_res.out_byte;
    out_next.frame_ready = head_rdy;
    out_next.fill_level  = FillOutW'(fill);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
      out_item  <= out_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FillW'(BufDepth))
    else $error("queue fill beyond buffer depth");

  a_fetch_after_removal: assert property (@(posedge clk) disable iff (rst)
    removal |=> (state == S_FETCH0) && b_valid && b_res.last_byte)
    else $error("frame removal did not start head re-read");

  a_no_adv_in_fetch: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> !accept && !b_adv)
    else $error("item moved while head bytes are re-read");

  a_last_is_given: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last_byte) |-> (out_item.status == ST_GIVEN))
    else $error("last byte flagged without a payload byte");

  a_mem_tag_live: assert property (@(posedge clk) disable iff (rst)
    b_from_mem |-> b_valid && $past(rd_en))
    else $error("payload byte expected without a buffer read");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import lpmd_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // idle percentages of each side, changed between phases
  int tx_idle_pct = 21;
  int rx_idle_pct = 73;

  // long receiver hold-off, requested by a test and counted by the receiver
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  int mismatch_count = 0;

  // queue mirror: byte store, head index, held bytes, payload bytes given
  logic [ByteW-1:0] mirror_mem [BufDepth];
  int unsigned      mirror_head = 0;
  int unsigned      mirror_fill = 0;
  int unsigned      mirror_rd_off = 0;

  out_item_t expected_results [$];

  length_prefixed_message_deframer_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [ByteW-1:0] mirror_peek(input int unsigned k);
    return mirror_mem[(mirror_head + k) % BufDepth];
  endfunction

  // length of the head frame, zero while fewer than two bytes are held
  function automatic int unsigned mirror_head_len();
    if (mirror_fill < 2) return 0;
    return {mirror_peek(0), mirror_peek(1)};
  endfunction

  function automatic bit mirror_ready();
    int unsigned len;
    len = mirror_head_len();
    return len != 0 && mirror_fill >= len + FrameOvh;
  endfunction

  // advance the mirror by one item and return the result it must give
  function automatic out_item_t deframe_step(input in_item_t it);
    out_item_t   r;
    int unsigned len;
    r = '0;
    if (it.opcode == OP_RECV) begin
      if (mirror_fill >= BufDepth) begin
        r.status = ST_DROPPED;
      end else begin
        mirror_mem[(mirror_head + mirror_fill) % BufDepth] = it.rx_byte;
        mirror_fill++;
        r.status = ST_STORED;
      end
    end else if (mirror_ready()) begin
      len = mirror_head_len();
      r.status = ST_GIVEN;
      r.frame_header = mirror_peek(2);
      r.frame_length = LenW'(len);
      if (mirror_rd_off >= len) mirror_rd_off = 0;
      r.out_byte = mirror_peek(FrameOvh + mirror_rd_off);
      mirror_rd_off++;
      // whole frame leaves after its last payload byte
      if (mirror_rd_off >= len) begin
        r.last_byte = 1'b1;
        mirror_head = (mirror_head + len + FrameOvh) % BufDepth;
        mirror_fill -= len + FrameOvh;
        mirror_rd_off = 0;
      end
    end else begin
      r.status = ST_EMPTY;
    end
    r.frame_ready = mirror_ready();
    r.fill_level = FillOutW'(mirror_fill);
    return r;
  endfunction

  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom_range(255));
  endfunction

  function automatic in_item_t recv_item(input logic [ByteW-1:0] b);
    in_item_t it;
    it.opcode = OP_RECV;
    it.rx_byte = b;
    return it;
  endfunction

  // rx_byte is don't-care on a read, so fill it with noise
  function automatic in_item_t read_item();
    in_item_t it;
    it.opcode = OP_READ;
    it.rx_byte = rand_byte();
    return it;
  endfunction

  // offer one item, with random gaps, and record its expected result once taken
  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(deframe_step(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: st=%0d byte=%02h hdr=%02h len=%0d last=%0b rdy=%0b fill=%0d",
                   out_item.status, out_item.out_byte, out_item.frame_header,
                   out_item.frame_length, out_item.last_byte, out_item.frame_ready,
                   out_item.fill_level);
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status || out_item.out_byte !== want.out_byte ||
            out_item.frame_header !== want.frame_header ||
            out_item.frame_length !== want.frame_length ||
            out_item.last_byte !== want.last_byte ||
            out_item.frame_ready !== want.frame_ready ||
            out_item.fill_level !== want.fill_level) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t: expected st=%0d byte=%02h hdr=%02h len=%0d last=%0b rdy=%0b fill=%0d",
                     $realtime, want.status, want.out_byte, want.frame_header,
                     want.frame_length, want.last_byte, want.frame_ready, want.fill_level);
            $display("               actual   st=%0d byte=%02h hdr=%02h len=%0d last=%0b rdy=%0b fill=%0d",
                     out_item.status, out_item.out_byte, out_item.frame_header,
                     out_item.frame_length, out_item.last_byte, out_item.frame_ready,
                     out_item.fill_level);
          end
        end
      end
    end
  end

  // short frames, empty reads, too few bytes held, receive during a frame read
  task automatic test_directed();
    push_item(read_item());
    push_item(recv_item(8'h00));
    push_item(read_item());
    push_item(recv_item(8'h02));
    push_item(recv_item(8'hFF));
    push_item(recv_item(8'h00));
    push_item(read_item());
    push_item(recv_item(8'h00));
    push_item(recv_item(8'h00));
    push_item(read_item());
    push_item(recv_item(8'h04));
    push_item(read_item());
    push_item(recv_item(8'h80));
    push_item(read_item());
    push_item(read_item());
    push_item(recv_item(8'h00));
    push_item(recv_item(8'h01));
    push_item(recv_item(8'h55));
    push_item(recv_item(8'hAA));
    push_item(read_item());
    push_item(read_item());
    while (mirror_ready()) push_item(read_item());
  endtask

  // a frame that fills the buffer exactly, then bytes dropped while full
  task automatic test_exact_fit();
    int unsigned plen;
    int unsigned n;
    plen = BufDepth - FrameOvh;
    push_item(recv_item(ByteW'(plen >> 8)));
    push_item(recv_item(ByteW'(plen)));
    push_item(recv_item(8'hA5));
    repeat (plen) push_item(recv_item(rand_byte()));
    repeat (3) push_item(recv_item(rand_byte()));
    n = 0;
    while (mirror_ready()) begin
      push_item(read_item());
      n++;
      if (n == plen / 2) push_item(recv_item(rand_byte()));
    end
  endtask

  // well-formed frames with random content, split reads and a little noise
  task automatic test_random_traffic(input int target);
    logic [ByteW-1:0] frame_bytes [$];
    int unsigned      plen;
    int               done;
    done = 0;
    while (done < target) begin
      if (frame_bytes.size() == 0) begin
        plen = ($urandom_range(19) == 0) ? $urandom_range(300, 256) : $urandom_range(24, 1);
        frame_bytes.push_back(ByteW'(plen >> 8));
        frame_bytes.push_back(ByteW'(plen));
        frame_bytes.push_back(rand_byte());
        repeat (plen) frame_bytes.push_back(rand_byte());
      end
      if (mirror_ready()) begin
        if ($urandom_range(1) == 0 || mirror_fill > 4000) push_item(read_item());
        else push_item(recv_item(frame_bytes.pop_front()));
        done++;
      end else if ($urandom_range(9) == 0) begin
        // read with nothing ready
        push_item(read_item());
      end else begin
        push_item(recv_item(frame_bytes.pop_front()));
        done++;
      end
    end
    // finish the partial frame and empty the queue
    while (frame_bytes.size() != 0) push_item(recv_item(frame_bytes.pop_front()));
    while (mirror_ready()) push_item(read_item());
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    int unsigned plen;
    hold_req <= hold_req + 1;
    repeat (5) begin
      plen = $urandom_range(6, 1);
      push_item(recv_item(ByteW'(plen >> 8)));
      push_item(recv_item(ByteW'(plen)));
      push_item(recv_item(rand_byte()));
      repeat (plen) push_item(recv_item(rand_byte()));
      repeat (plen) push_item(read_item());
    end
    wait_drained();
  endtask

  // zero-length frame blocks the queue for good; fill up until bytes drop
  task automatic test_blocked_queue();
    push_item(recv_item(8'h00));
    push_item(recv_item(8'h00));
    push_item(recv_item(8'h3C));
    push_item(read_item());
    while (mirror_fill < BufDepth) begin
      if ($urandom_range(15) == 0) push_item(read_item());
      else push_item(recv_item(rand_byte()));
    end
    repeat (4) push_item(recv_item(rand_byte()));
    push_item(read_item());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    tx_idle_pct = 21;
    rx_idle_pct = 73;
    test_directed();
    test_exact_fit();
    test_random_traffic(270);

    // sender idles heavily, receiver lightly
    tx_idle_pct = 73;
    rx_idle_pct = 21;
    test_random_traffic(270);

    // no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(270);
    test_backpressure();
    test_blocked_queue();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
